// ----- design/rgba_to_cielab_core_macros.svh -----
// assertion macros for the rgb2lab pipeline
`ifndef RGBA_TO_CIELAB_CORE_MACROS_SVH
`define RGBA_TO_CIELAB_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RGB2LAB_ASSERT(lbl, clk_i, rst_ni, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rgb2lab check failed");
`define RGB2LAB_ASSERT_RST(lbl, clk_i, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rgb2lab reset check failed");
`else
`define RGB2LAB_ASSERT(lbl, clk_i, rst_ni, prop)
`define RGB2LAB_ASSERT_RST(lbl, clk_i, prop)
`endif

`endif

// ----- design/rgb2lab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rgb2lab_pkg;

  localparam int COMP_FRAC_BITS  = 12;
  localparam int CURVE_ADDR_BITS = 10;
  localparam int OUT_FRAC_BITS   = 8;

  // Q16 values 0..1.0 inclusive
  typedef logic [16:0] lin_t;
  typedef logic signed [27:0] lab_t;

  function automatic lin_t gamma_entry(input int unsigned k, input int abits);
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] lim;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] base;
    logic [63:0] sq;
    logic [63:0] q2;
    logic [63:0] q4;
    logic [63:0] q5;
    den = 64'd1055 << abits;
    num = (64'(k) * 64'd1000 + (64'd55 << abits)) << 30;
    lim = num + (64'd1055 << (abits - 1));
    lo = 64'd0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (mid * den <= lim) lo = mid;
      else hi = mid - 64'd1;
    end
    base = lo;
    sq = (base * base + (64'd1 << 29)) >> 30;
    lo = 64'd0;
    hi = 64'd65536;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      q2 = (mid * mid) >> 16;
      q4 = q2 * q2;
      q5 = (q4 >> 16) * mid;
      if (q5 <= (sq << 2)) lo = mid;
      else hi = mid - 64'd1;
    end
    return lin_t'((sq * lo + (64'd1 << 29)) >> 30);
  endfunction

  function automatic lin_t cube_entry(input int unsigned k, input int abits);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    target = 64'(k) << (48 - abits);
    lo = 64'd0;
    hi = 64'd65536;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (mid * mid * mid <= target) lo = mid;
      else hi = mid - 64'd1;
    end
    return lin_t'(lo);
  endfunction

  // round a Q16 value to ofb fraction bits, half away from zero
  function automatic lab_t to_q(input lab_t v, input int ofb);
    logic [27:0] mag;
    logic [27:0] rnd;
    mag = v[27] ? 28'(-v) : 28'(v);
    rnd = (mag + (28'd1 << (15 - ofb))) >> (16 - ofb);
    return v[27] ? -$signed(rnd) : $signed(rnd);
  endfunction

endpackage
`default_nettype wire

// ----- design/rgb2lab_cdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rgb2lab_cdiv #(
  parameter int N_W = 33,
  parameter int DIV = 65025,
  parameter int Q_W = 17
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [N_W-1:0] n,
  output logic      [Q_W-1:0] q_r
);

  localparam int DW = $clog2(DIV);
  localparam int S  = N_W + DW - 1;
  localparam logic [63:0] M64 = (64'd1 << S) / 64'(DIV);
  localparam logic [N_W-1:0] M = M64[N_W-1:0];

  logic [2*N_W-1:0] prod;
  logic [Q_W-1:0]   q0_r;
  logic [N_W-1:0]   n_r;
  logic [N_W-1:0]   rem;
  logic [Q_W-1:0]   q_nxt;

  assign prod = (2*N_W)'(n) * (2*N_W)'(M);

  always_ff @(posedge clk) begin
    if (en) begin
      q0_r <= Q_W'(prod >> S);
      n_r  <= n;
    end
  end

  // estimate is low by at most one
  assign rem   = n_r - N_W'(N_W'(q0_r) * N_W'(DIV));
  assign q_nxt = (rem >= N_W'(DIV)) ? q0_r + 1'b1 : q0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/rgb2lab_curve_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rgb2lab_curve_rom #(
  parameter int A    = rgb2lab_pkg::CURVE_ADDR_BITS,
  parameter bit CUBE = 1'b0
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [A:0]         addr0,
  input  wire logic [A:0]         addr1,
  output rgb2lab_pkg::lin_t       data0_r,
  output rgb2lab_pkg::lin_t       data1_r
);

  localparam int DEPTH = (1 << A) + 1;

  rgb2lab_pkg::lin_t rom_w [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    if (CUBE) begin : g_cube
      assign rom_w[k] = rgb2lab_pkg::cube_entry(k, A);
    end else begin : g_gamma
      assign rom_w[k] = rgb2lab_pkg::gamma_entry(k, A);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data0_r <= rom_w[addr0];
      data1_r <= rom_w[addr1];
    end
  end

endmodule
`default_nettype wire

// ----- design/rgb2lab_lin.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rgb2lab_lin #(
  parameter int F = rgb2lab_pkg::COMP_FRAC_BITS,
  parameter int A = rgb2lab_pkg::CURVE_ADDR_BITS
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [7:0]   chan,
  input  wire logic [7:0]   alpha,
  output rgb2lab_pkg::lin_t lin_r
);

  localparam int NC_W   = 16 + F;
  localparam int SY_W   = F + 24;
  localparam int IP_W   = F + 18;
  localparam int GAM_TH = (4045 << F) / 100000;

  logic [15:0]       num_r;
  logic [NC_W-1:0]   nc;
  logic [F:0]        comp;
  logic [F+A:0]      pos;
  logic [A:0]        k0;
  logic [A:0]        k1;
  logic              hi;
  logic              hi4_r;
  logic [F-1:0]      frac4_r;
  rgb2lab_pkg::lin_t e0;
  rgb2lab_pkg::lin_t e1;
  logic [SY_W-1:0]   sy_full;
  rgb2lab_pkg::lin_t small_q;
  rgb2lab_pkg::lin_t d;
  logic [IP_W-1:0]   ipw;
  rgb2lab_pkg::lin_t ip5_r;
  rgb2lab_pkg::lin_t e0_5_r;
  logic              hi5_r;

  // blend over white
  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= 16'({8'b0, chan} * {8'b0, alpha} + 16'd255 * (16'd255 - {8'b0, alpha}));
    end
  end

  assign nc = (NC_W'(num_r) << F) + NC_W'(32512);

  rgb2lab_cdiv #(.N_W(NC_W), .DIV(65025), .Q_W(F + 1)) u_comp (
    .clk (clk),
    .en  (en),
    .n   (nc),
    .q_r (comp)
  );

  assign hi  = comp > (F + 1)'(GAM_TH);
  assign pos = (F + A + 1)'(comp) << A;
  assign k0  = pos[F+A:F];
  assign k1  = (k0 == (A + 1)'(1 << A)) ? k0 : k0 + 1'b1;

  rgb2lab_curve_rom #(.A(A), .CUBE(1'b0)) u_rom (
    .clk     (clk),
    .en      (en),
    .addr0   (k0),
    .addr1   (k1),
    .data0_r (e0),
    .data1_r (e1)
  );

  // linear segment near black
  assign sy_full = SY_W'(comp) * SY_W'(6553600) + (SY_W'(646) << F);

  rgb2lab_cdiv #(.N_W(23), .DIV(1292), .Q_W(17)) u_small (
    .clk (clk),
    .en  (en),
    .n   (sy_full[F+22:F]),
    .q_r (small_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      hi4_r   <= hi;
      frac4_r <= pos[F-1:0];
    end
  end

  assign d   = (e1 > e0) ? e1 - e0 : '0;
  assign ipw = IP_W'(d) * IP_W'(frac4_r) + (IP_W'(1) << (F - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      ip5_r  <= 17'(ipw >> F);
      e0_5_r <= e0;
      hi5_r  <= hi4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r <= hi5_r ? e0_5_r + ip5_r : small_q;
    end
  end

endmodule
`default_nettype wire

// ----- design/rgb2lab_cief.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rgb2lab_cief #(
  parameter int A   = rgb2lab_pkg::CURVE_ADDR_BITS,
  parameter int MUL = 10,
  parameter int ADD = 47523,
  parameter int DIV = 95047
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [29:0]  s,
  output rgb2lab_pkg::lin_t f_r
);

  localparam int CUBE_TH  = (8856 * 65536) / 1000000;
  localparam int CUBE_OFS = 16000 * 65536 + 58000;

  logic [32:0]       n;
  rgb2lab_pkg::lin_t t;
  rgb2lab_pkg::lin_t tc;
  logic              hi;
  logic [A:0]        k0;
  logic [A:0]        k1;
  logic [15:0]       frac;
  rgb2lab_pkg::lin_t e0;
  rgb2lab_pkg::lin_t e1;
  logic              hi10_r;
  logic [15:0]       frac10_r;
  logic [30:0]       n2;
  rgb2lab_pkg::lin_t small_q;
  rgb2lab_pkg::lin_t d;
  logic [33:0]       ipw;
  rgb2lab_pkg::lin_t ip11_r;
  rgb2lab_pkg::lin_t e0_11_r;
  logic              hi11_r;

  assign n = 33'(s) * 33'(MUL) + 33'(ADD);

  rgb2lab_cdiv #(.N_W(33), .DIV(DIV), .Q_W(17)) u_norm (
    .clk (clk),
    .en  (en),
    .n   (n),
    .q_r (t)
  );

  assign hi   = t > 17'(CUBE_TH);
  assign tc   = (t > 17'd65536) ? 17'd65536 : t;
  assign k0   = tc[16:16-A];
  assign k1   = (k0 == (A + 1)'(1 << A)) ? k0 : k0 + 1'b1;
  assign frac = {tc[15-A:0], {A{1'b0}}};

  rgb2lab_curve_rom #(.A(A), .CUBE(1'b1)) u_rom (
    .clk     (clk),
    .en      (en),
    .addr0   (k0),
    .addr1   (k1),
    .data0_r (e0),
    .data1_r (e1)
  );

  // linear segment below the knee
  assign n2 = 31'(t[9:0]) * 31'(903292) + 31'(CUBE_OFS);

  rgb2lab_cdiv #(.N_W(31), .DIV(116000), .Q_W(17)) u_small (
    .clk (clk),
    .en  (en),
    .n   (n2),
    .q_r (small_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      hi10_r   <= hi;
      frac10_r <= frac;
    end
  end

  assign d   = (e1 > e0) ? e1 - e0 : '0;
  assign ipw = 34'(d) * 34'(frac10_r) + 34'(1 << 15);

  always_ff @(posedge clk) begin
    if (en) begin
      ip11_r  <= 17'(ipw >> 16);
      e0_11_r <= e0;
      hi11_r  <= hi10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= hi11_r ? e0_11_r + ip11_r : small_q;
    end
  end

endmodule
`default_nettype wire

// ----- design/rgba_to_cielab_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// RGBA to CIELAB (D65) converter. Takes one pixel word per clock and returns its L*, a*, b*;
// the rate of one word per cycle holds except while a finished word sits unread at the
// output under out_stall, which is the only time the whole pipeline freezes. Partly transparent
// pixels are blended over white, fully transparent ones give zero. The sRGB gamma and CIE
// cube-root curves sit in six ROMs of 2^CURVE_ADDR_BITS+1 entries (one per channel and per
// axis), each read at two neighboring addresses per cycle for linear interpolation.
`include "rgba_to_cielab_core_macros.svh"
module rgba_to_cielab_core #(
  parameter int COMP_FRAC_BITS  = rgb2lab_pkg::COMP_FRAC_BITS,
  parameter int CURVE_ADDR_BITS = rgb2lab_pkg::CURVE_ADDR_BITS,
  parameter int OUT_FRAC_BITS   = rgb2lab_pkg::OUT_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  input  wire logic [7:0]         in_alpha,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [14:0]             out_lightness,
  output logic signed [15:0]      out_a_star,
  output logic signed [15:0]      out_b_star
);

  localparam int LAT   = 14;
  localparam int L_MAX = 100 << OUT_FRAC_BITS;

  logic              adv;
  logic [LAT-1:1]    v_r;
  logic [LAT-1:1]    z_r;
  logic              out_valid_r;
  rgb2lab_pkg::lin_t lr;
  rgb2lab_pkg::lin_t lg;
  rgb2lab_pkg::lin_t lb;
  logic [29:0]       sx_r;
  logic [29:0]       sy_r;
  logic [29:0]       sz_r;
  rgb2lab_pkg::lin_t fx;
  rgb2lab_pkg::lin_t fy;
  rgb2lab_pkg::lin_t fz;
  rgb2lab_pkg::lab_t l_r;
  rgb2lab_pkg::lab_t a_r;
  rgb2lab_pkg::lab_t b_r;
  rgb2lab_pkg::lab_t lq;
  rgb2lab_pkg::lab_t aq;
  rgb2lab_pkg::lab_t bq;
  logic [14:0]        l_nxt;
  logic signed [15:0] a_nxt;
  logic signed [15:0] b_nxt;
  logic [14:0]        out_lightness_r;
  logic signed [15:0] out_a_star_r;
  logic signed [15:0] out_b_star_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      z_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[LAT-2:1], in_valid};
      z_r         <= {z_r[LAT-2:1], in_alpha == 8'd0};
      out_valid_r <= v_r[LAT-1];
    end
  end

  rgb2lab_lin #(.F(COMP_FRAC_BITS), .A(CURVE_ADDR_BITS)) u_lin_r (
    .clk (clk), .en (adv), .chan (in_red), .alpha (in_alpha), .lin_r (lr)
  );
  rgb2lab_lin #(.F(COMP_FRAC_BITS), .A(CURVE_ADDR_BITS)) u_lin_g (
    .clk (clk), .en (adv), .chan (in_green), .alpha (in_alpha), .lin_r (lg)
  );
  rgb2lab_lin #(.F(COMP_FRAC_BITS), .A(CURVE_ADDR_BITS)) u_lin_b (
    .clk (clk), .en (adv), .chan (in_blue), .alpha (in_alpha), .lin_r (lb)
  );

  // rgb to xyz matrix, scaled by 10000
  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= 30'(30'd4124 * 30'(lr) + 30'd3576 * 30'(lg) + 30'd1805 * 30'(lb));
      sy_r <= 30'(30'd2126 * 30'(lr) + 30'd7152 * 30'(lg) + 30'd722 * 30'(lb));
      sz_r <= 30'(30'd193 * 30'(lr) + 30'd1192 * 30'(lg) + 30'd9505 * 30'(lb));
    end
  end

  rgb2lab_cief #(.A(CURVE_ADDR_BITS), .MUL(10), .ADD(47523), .DIV(95047)) u_fx (
    .clk (clk), .en (adv), .s (sx_r), .f_r (fx)
  );
  rgb2lab_cief #(.A(CURVE_ADDR_BITS), .MUL(1), .ADD(5000), .DIV(10000)) u_fy (
    .clk (clk), .en (adv), .s (sy_r), .f_r (fy)
  );
  rgb2lab_cief #(.A(CURVE_ADDR_BITS), .MUL(10), .ADD(54441), .DIV(108883)) u_fz (
    .clk (clk), .en (adv), .s (sz_r), .f_r (fz)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      l_r <= $signed(28'(fy)) * 28'sd116 - 28'sd1048576;
      a_r <= ($signed(28'(fx)) - $signed(28'(fy))) * 28'sd500;
      b_r <= ($signed(28'(fy)) - $signed(28'(fz))) * 28'sd200;
    end
  end

  assign lq = rgb2lab_pkg::to_q(l_r, OUT_FRAC_BITS);
  assign aq = rgb2lab_pkg::to_q(a_r, OUT_FRAC_BITS);
  assign bq = rgb2lab_pkg::to_q(b_r, OUT_FRAC_BITS);

  always_comb begin
    if (lq < 0) l_nxt = '0;
    else if (lq > 28'sd32767) l_nxt = 15'h7fff;
    else l_nxt = lq[14:0];
    if (aq < -28'sd32768) a_nxt = -16'sd32768;
    else if (aq > 28'sd32767) a_nxt = 16'sd32767;
    else a_nxt = aq[15:0];
    if (bq < -28'sd32768) b_nxt = -16'sd32768;
    else if (bq > 28'sd32767) b_nxt = 16'sd32767;
    else b_nxt = bq[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lightness_r <= z_r[LAT-1] ? '0 : l_nxt;
      out_a_star_r    <= z_r[LAT-1] ? '0 : a_nxt;
      out_b_star_r    <= z_r[LAT-1] ? '0 : b_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lightness = out_lightness_r;
  assign out_a_star    = out_a_star_r;
  assign out_b_star    = out_b_star_r;

  `RGB2LAB_ASSERT(a_enter, clk, rst_n, !in_stall |=> (v_r[1] == $past(in_valid)))
  `RGB2LAB_ASSERT(a_clear_px, clk, rst_n, (v_r[LAT-1] && z_r[LAT-1] && !in_stall) |=> (out_lightness == '0 && out_a_star == '0 && out_b_star == '0))
  `RGB2LAB_ASSERT(a_l_range, clk, rst_n, out_valid |-> (32'(out_lightness) <= L_MAX))
  `RGB2LAB_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule
`default_nettype wire
